@@ rtl/core/tlpc_pkg.sv @@
package tlpc_pkg;

    localparam int PACKET_BYTES = 64;
    localparam int IDX_W        = $clog2(PACKET_BYTES);
    localparam int LEN_W        = $clog2(PACKET_BYTES + 1);
    localparam int ADDR_W       = IDX_W + 1;
    localparam int RAM_DEPTH    = 2 ** ADDR_W;
    localparam int BYTE_W       = 8;
    localparam int CNT_W        = 16;
    localparam int INFL_W       = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [INFL_W-1:0] MAX_INFLIGHT_RST = 4'd4;
    localparam logic [BYTE_W-1:0] LINE_END_RST     = 8'd10;
    localparam logic [INFL_W-1:0] INFL_MAX         = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX          = '1;

    typedef enum logic {
        CMD_BYTE   = 1'b0,
        CMD_CREDIT = 1'b1
    } cmd_t;

    typedef enum logic {
        CFG_MAX_INFLIGHT = 1'b0,
        CFG_LINE_END     = 1'b1
    } cfg_idx_t;

    // one closed packet, as handed from the front to the back
    typedef struct packed {
        logic              dropped;
        logic              bank;
        logic [LEN_W-1:0]  len;
        logic [CNT_W-1:0]  drop_count;
        logic [INFL_W-1:0] inflight;
    } desc_t;

    // back tells the front that a buffer bank has been read out
    typedef struct packed {
        logic valid;
        logic bank;
    } bank_rel_t;

endpackage

@@ rtl/core/tx_line_packetizer_credit_core.sv @@
// Line packetizer with credit flow control.
//
// Input channel (in_valid / in_stall): command 0 carries tx_byte into the
// packet buffer; command 1 returns one send credit and gives no result.
// A packet closes on the line-end byte or when the buffer is full. It is
// then sent as a run of bytes with last_of_packet on the final one, or, with
// no credit left, replaced by a single result flagged dropped.
// Output channel (out_valid / out_stall): one result per cycle while not
// stalled; a stalled result holds.
// Config port (cfg_valid / cfg_ready, always ready): index 0 max_inflight,
// index 1 line_end_char; write only while the block is idle.
// Results pass the packet queue, the active-packet register, the read stage
// and the output register; bytes follow one per cycle while the output is not
// stalled. Input takes one item per cycle; the buffer is two banks, so it
// stalls when a third packet must start filling before the oldest has been
// read out, or when the two-entry packet queue is full. Full packets sustain
// about one item per cycle into an unstalled output but stall at bank swaps.
// Reset clears the buffer fill, credit and drop counters and restores the
// register defaults; buffer contents are not cleared.
module tx_line_packetizer_credit_core
    import tlpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last_of_packet,
    output logic              dropped,
    output logic [CNT_W-1:0]  drop_count,
    output logic [INFL_W-1:0] inflight_now
);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BYTE_W-1:0] rd_data;
    logic              desc_push;
    desc_t             desc;
    logic              desc_full;
    logic              q_valid;
    logic              q_pop;
    desc_t             q_head;
    bank_rel_t         rel;
    logic [1:0]        busy;

    assign cfg_ready = 1'b1;

    tlpc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .tx_byte   (tx_byte),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .desc_push (desc_push),
        .desc      (desc),
        .desc_full (desc_full),
        .rel       (rel),
        .busy      (busy)
    );

    tlpc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tlpc_desc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (desc_push),
        .din       (desc),
        .full      (desc_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    tlpc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .rel            (rel),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_of_packet (last_of_packet),
        .dropped        (dropped),
        .drop_count     (drop_count),
        .inflight_now   (inflight_now)
    );

    a_drop_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> last_of_packet && (out_byte == '0))
        else $error("drop result without last marker or with nonzero byte");

    a_release_busy_bank: assert property (@(posedge clk) disable iff (!rst_n)
        rel.valid |-> busy[rel.bank])
        else $error("bank released that was not in use");

    a_full_banks_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (busy == 2'b11) |-> in_stall)
        else $error("input taken with both buffer banks draining");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        desc_push |-> !desc_full)
        else $error("packet queued into a full queue");

endmodule

@@ rtl/core/tlpc_ram.sv @@
module tlpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/tlpc_front.sv @@
module tlpc_front
    import tlpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [BYTE_W-1:0] tx_byte,
    input  logic              cfg_wr,
    input  logic              cfg_index,
    input  logic [BYTE_W-1:0] cfg_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output logic              desc_push,
    output desc_t             desc,
    input  logic              desc_full,
    input  bank_rel_t         rel,
    output logic [1:0]        busy
);

    logic [INFL_W-1:0] max_inflight_reg, max_inflight_next;
    logic [BYTE_W-1:0] line_end_reg, line_end_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [INFL_W-1:0] inflight_reg, inflight_next;
    logic [CNT_W-1:0]  drops_reg, drops_next;
    logic              wr_bank_reg, wr_bank_next;
    logic [1:0]        busy_reg, busy_next;

    logic              accept;
    logic              is_byte;
    logic [LEN_W-1:0]  fill_inc;
    logic              flush;
    logic              has_credit;

    // hold input while the queue is full or the bank being filled is still draining
    assign in_stall   = desc_full || busy_reg[wr_bank_reg];
    assign accept     = in_valid && !in_stall;
    assign is_byte    = (cmd_t'(command) == CMD_BYTE);
    assign fill_inc   = fill_reg + LEN_W'(1);
    assign flush      = is_byte && ((tx_byte == line_end_reg) ||
                                    (fill_inc == LEN_W'(PACKET_BYTES)));
    assign has_credit = (inflight_reg < max_inflight_reg);

    assign wr_en   = accept && is_byte;
    assign wr_addr = {wr_bank_reg, fill_reg[IDX_W-1:0]};
    assign wr_data = tx_byte;

    always_comb
    begin
        max_inflight_next = max_inflight_reg;
        line_end_next     = line_end_reg;
        fill_next         = fill_reg;
        inflight_next     = inflight_reg;
        drops_next        = drops_reg;
        wr_bank_next      = wr_bank_reg;
        busy_next         = busy_reg;

        if (accept)
        begin
            if (!is_byte)
            begin
                if (inflight_reg != '0)
                begin
                    inflight_next = inflight_reg - INFL_W'(1);
                end
            end
            else if (flush)
            begin
                fill_next = '0;
                if (has_credit)
                begin
                    if (inflight_reg != INFL_MAX)
                    begin
                        inflight_next = inflight_reg + INFL_W'(1);
                    end
                    busy_next[wr_bank_reg] = 1'b1;
                    wr_bank_next           = ~wr_bank_reg;
                end
                else if (drops_reg != CNT_MAX)
                begin
                    drops_next = drops_reg + CNT_W'(1);
                end
            end
            else
            begin
                fill_next = fill_inc;
            end
        end

        if (rel.valid)
        begin
            busy_next[rel.bank] = 1'b0;
        end

        if (cfg_wr)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_INFLIGHT: max_inflight_next = cfg_data[INFL_W-1:0];
                CFG_LINE_END:     line_end_next     = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_inflight_reg <= MAX_INFLIGHT_RST;
            line_end_reg     <= LINE_END_RST;
            fill_reg         <= '0;
            inflight_reg     <= '0;
            drops_reg        <= '0;
            wr_bank_reg      <= 1'b0;
            busy_reg         <= '0;
        end
        else
        begin
            max_inflight_reg <= max_inflight_next;
            line_end_reg     <= line_end_next;
            fill_reg         <= fill_next;
            inflight_reg     <= inflight_next;
            drops_reg        <= drops_next;
            wr_bank_reg      <= wr_bank_next;
            busy_reg         <= busy_next;
        end
    end

    assign desc_push       = accept && flush;
    assign desc.dropped    = !has_credit;
    assign desc.bank       = wr_bank_reg;
    assign desc.len        = fill_inc;
    assign desc.drop_count = drops_next;
    assign desc.inflight   = inflight_next;
    assign busy            = busy_reg;

endmodule

@@ rtl/core/tlpc_desc_fifo.sv @@
module tlpc_desc_fifo
    import tlpc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t din,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output desc_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    desc_t             mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] cnt_reg, cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == CNT_QW'(QUEUE_DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_QW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

@@ rtl/core/tlpc_back.sv @@
module tlpc_back
    import tlpc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  desc_t             q_head,
    output logic              q_pop,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [BYTE_W-1:0] rd_data,
    output bank_rel_t         rel,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [BYTE_W-1:0] out_byte,
    output logic              last_of_packet,
    output logic              dropped,
    output logic [CNT_W-1:0]  drop_count,
    output logic [INFL_W-1:0] inflight_now
);

    typedef struct packed {
        logic              last;
        logic              dropped;
        logic [CNT_W-1:0]  drop_count;
        logic [INFL_W-1:0] inflight;
    } meta_t;

    logic              act_valid_reg, act_valid_next;
    desc_t             act_reg, act_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              s1_valid_reg, s1_valid_next;
    meta_t             s1_reg, s1_next;
    logic              out_valid_reg, out_valid_next;
    meta_t             out_reg, out_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;

    logic adv2;
    logic issue;
    logic is_last;

    assign adv2    = !out_valid_reg || !out_stall;
    assign issue   = act_valid_reg && (!s1_valid_reg || adv2);
    assign is_last = act_reg.dropped ||
                     ((LEN_W'(idx_reg) + LEN_W'(1)) == act_reg.len);

    assign rd_en     = issue && !act_reg.dropped;
    assign rd_addr   = {act_reg.bank, idx_reg};
    assign rel.valid = issue && is_last && !act_reg.dropped;
    assign rel.bank  = act_reg.bank;
    assign q_pop     = q_valid && (!act_valid_reg || (issue && is_last));

    always_comb
    begin
        act_valid_next = act_valid_reg;
        act_next       = act_reg;
        idx_next       = idx_reg;
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        out_byte_next  = out_byte_reg;

        if (issue)
        begin
            if (is_last)
            begin
                act_valid_next = 1'b0;
                idx_next       = '0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
            end
        end
        if (q_pop)
        begin
            act_valid_next = 1'b1;
            act_next       = q_head;
            idx_next       = '0;
        end

        // advance the read stage into the output register
        if (adv2)
        begin
            out_valid_next = s1_valid_reg;
            out_next       = s1_reg;
            out_byte_next  = s1_reg.dropped ? '0 : rd_data;
        end

        if (issue)
        begin
            s1_valid_next      = 1'b1;
            s1_next.last       = is_last;
            s1_next.dropped    = act_reg.dropped;
            s1_next.drop_count = act_reg.drop_count;
            s1_next.inflight   = act_reg.inflight;
        end
        else if (adv2)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_valid_reg <= 1'b0;
            idx_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            act_valid_reg <= act_valid_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        s1_reg       <= s1_next;
        out_reg      <= out_next;
        out_byte_reg <= out_byte_next;
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = out_byte_reg;
    assign last_of_packet = out_reg.last;
    assign dropped        = out_reg.dropped;
    assign drop_count     = out_reg.drop_count;
    assign inflight_now   = out_reg.inflight;

endmodule
